// File: hw/rtl/ppb_pkg.sv
// package: constants, types and helpers for the popularity palette builder
`default_nettype none
package ppb_pkg;
  localparam int unsigned BinDepth  = 8192;
  localparam int unsigned SlotDepth = 256;
  localparam int unsigned BinW      = 13;
  localparam int unsigned SlotW     = 8;
  localparam int unsigned ColourW   = 13;
  localparam int unsigned CountW    = 32;
  localparam logic [31:0] UsedMark  = 32'hFFFF_FFFF;
  localparam logic [31:0] WeightMax = 32'hFFFF_FFFE;

  typedef enum logic [1:0] {
    CMD_LOAD  = 2'd0,
    CMD_BUILD = 2'd1,
    CMD_RDBIN = 2'd2,
    CMD_RDSLT = 2'd3
  } cmd_t;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [12:0] bin_number;
    logic [4:0]  src_hue;
    logic [3:0]  src_sat;
    logic [3:0]  src_light;
    logic [31:0] bin_weight;
    logic [7:0]  slot_number;
  } in_item_t;

  typedef struct packed {
    logic [7:0] palette_index;
    logic [4:0] out_hue;
    logic [3:0] out_sat;
    logic [3:0] out_light;
    logic       is_top;
    logic [8:0] used_slots;
  } out_item_t;

  // bin entry: colour, count, slot, top flag
  typedef struct packed {
    logic [12:0] colour;
    logic [31:0] count;
    logic [7:0]  slot;
    logic        top;
  } bin_ent_t;
  localparam int unsigned BinEntW = $bits(bin_ent_t);

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_RDWAIT, ST_OUT,
    ST_SRCH_RD, ST_SRCH, ST_PICK_RD, ST_PICK_WR,
    ST_MAP_RD, ST_MAP_BIN, ST_MAP_SLOT, ST_MAP_WR
  } state_t;

  // scaled squared axis difference: trunc(d*d/255), d = trunc(diff*255/levels)
  // levels are powers of two here, so trunc toward zero on magnitude
  function automatic logic [15:0] axis_term(input logic [4:0] a, input logic [4:0] b,
                                            input logic [2:0] sh);
    logic [4:0]  m;
    logic [12:0] p;
    logic [7:0]  d;
    logic [15:0] sq;
    logic [16:0] q;
    begin
      m  = (a >= b) ? a - b : b - a;
      p  = {8'd0, m} * 13'd255;
      d  = 8'(p >> sh);
      sq = {8'd0, d} * {8'd0, d};
      // divide by 255: (x + (x >> 8) + 1) >> 8, exact for x below 65280
      q  = {1'b0, sq} + 17'(sq[15:8]) + 17'd1;
      axis_term = {7'd0, q[16:8]};
    end
  endfunction
endpackage
`default_nettype wire

// File: hw/rtl/ppb_if.sv
// valid/ready channel interfaces for input and result items
`default_nettype none
interface ppb_in_if;
  logic valid;
  logic ready;
  ppb_pkg::in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface ppb_out_if;
  logic valid;
  logic ready;
  ppb_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/popularity_palette_builder.sv
// top level: histogram store, palette build sequencer and read port
//
//   channel   dir  transfer when           payload
//   in_ch     in   valid && ready          cmd, bin, hsl, weight, slot
//   out_ch    out  valid && ready          index, hsl, is_top, used_slots
//
// steps: a load reads the old entry, then writes it back (no result is sent);
//   a slot read reads the slot memory, a bin read its entry then its slot, plus output wait
// build: 256 searches over all 8192 bins for the largest unused count, then a
//   nearest-slot walk per unused bin on the slot memory read port, used bins skipped
// reset: clearing pass over the bin memory, the slot memory cleared in
//   the same pass over its 256 entries, no transfer taken meanwhile
// one item at a time; ready is low until the result is transferred, or for a load until written back
`default_nettype none
module popularity_palette_builder (
  input wire logic clk,
  input wire logic rst,
  ppb_in_if.sink   in_ch,
  ppb_out_if.source out_ch
);
  import ppb_pkg::*;

  state_t state, state_next;

  // bin memory
  logic           b_we;
  logic [12:0]    b_waddr, b_raddr;
  bin_ent_t       b_wdata, b_rdata;
  logic [BinEntW-1:0] b_rraw;
  ppb_ram #(.Width(BinEntW), .Depth(BinDepth)) u_bin (
    .clk, .we(b_we), .waddr(b_waddr), .wdata(b_wdata), .raddr(b_raddr), .rdata(b_rraw));
  assign b_rdata = bin_ent_t'(b_rraw);

  // slot memory
  logic         s_we;
  logic [7:0]   s_waddr, s_raddr;
  logic [12:0]  s_wdata, s_rdata;
  ppb_ram #(.Width(ColourW), .Depth(SlotDepth)) u_slot (
    .clk, .we(s_we), .waddr(s_waddr), .wdata(s_wdata), .raddr(s_raddr), .rdata(s_rdata));

  // sequencer registers
  logic [13:0] idx;         // bin walk counter, carries past the last bin
  logic [8:0]  slot;        // slot walk counter
  logic [12:0] pick;
  logic [31:0] best;
  logic [8:0]  filled;
  logic [8:0]  slots_filled;
  in_item_t    req;
  out_item_t   res;
  bin_ent_t    cur;         // bin being mapped
  logic [17:0] dbest;
  logic [7:0]  dslot;
  logic        rd_pipe;     // slot read data valid in map walk

  logic [13:0] idx_next;
  logic [8:0]  slot_next, filled_next, slots_filled_next;
  logic [12:0] pick_next;
  logic [31:0] best_next;
  in_item_t    req_next;
  out_item_t   res_next;
  bin_ent_t    cur_next;
  logic [17:0] dbest_next, slot_cost;
  logic [7:0]  dslot_next;
  logic        rd_pipe_next;

  assign in_ch.ready  = (state == ST_IDLE);
  assign out_ch.valid = (state == ST_OUT);
  assign out_ch.data  = res;

  // distance between the current bin and the slot colour on the read port
  always_comb begin
    slot_cost = 18'(axis_term(cur.colour[12:8], s_rdata[12:8], 3'd5))
              + 18'(axis_term({1'b0, cur.colour[7:4]}, {1'b0, s_rdata[7:4]}, 3'd4))
              + 18'(axis_term({1'b0, cur.colour[3:0]}, {1'b0, s_rdata[3:0]}, 3'd4));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      idx <= '0;
      slots_filled <= '0;
    end else begin
      state <= state_next;
      idx <= idx_next;
      slots_filled <= slots_filled_next;
    end
    slot <= slot_next; pick <= pick_next; best <= best_next; filled <= filled_next;
    req <= req_next; res <= res_next; cur <= cur_next; dbest <= dbest_next;
    dslot <= dslot_next; rd_pipe <= rd_pipe_next;
  end

  always_comb begin
    state_next = state; idx_next = idx; slot_next = slot; pick_next = pick;
    best_next = best; filled_next = filled; slots_filled_next = slots_filled;
    req_next = req; res_next = res; cur_next = cur; dbest_next = dbest;
    dslot_next = dslot; rd_pipe_next = 1'b0;
    b_we = 1'b0; b_waddr = idx[12:0]; b_wdata = '0; b_raddr = idx[12:0];
    s_we = 1'b0; s_waddr = idx[7:0]; s_wdata = '0; s_raddr = slot[7:0];
    unique case (state)
      ST_CLEAR: begin
        // zero both memories, one entry per cycle
        b_we = 1'b1;
        s_we = (idx < 14'd256);
        idx_next = idx + 14'd1;
        if (idx == 14'(BinDepth - 1)) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_ch.valid) begin
          req_next = in_ch.data;
          res_next = '0;
          res_next.used_slots = slots_filled;
          unique case (cmd_t'(in_ch.data.cmd))
            CMD_LOAD: begin
              b_we = 1'b1;
              b_waddr = in_ch.data.bin_number;
              b_raddr = in_ch.data.bin_number;
              state_next = ST_RDWAIT;  // fetch old slot for read-modify-write
            end
            CMD_BUILD: begin
              slot_next = '0; filled_next = '0; idx_next = '0;
              best_next = '0; pick_next = '0;
              state_next = ST_SRCH_RD;
            end
            CMD_RDBIN: begin
              b_raddr = in_ch.data.bin_number;
              state_next = ST_RDWAIT;
            end
            CMD_RDSLT: begin
              s_raddr = in_ch.data.slot_number;
              state_next = ST_RDWAIT;
            end
            default: ;
          endcase
          // loads write after the read; cancel this cycle's write
          b_we = 1'b0;
        end
      end
      ST_RDWAIT: begin
        unique case (cmd_t'(req.cmd))
          CMD_LOAD: begin
            b_we = 1'b1;
            b_waddr = req.bin_number;
            b_wdata.colour = {req.src_hue, req.src_sat, req.src_light};
            b_wdata.count = (req.bin_weight == UsedMark) ? WeightMax : req.bin_weight;
            b_wdata.slot = b_rdata.slot;
            b_wdata.top = 1'b0;
            state_next = ST_IDLE;
          end
          CMD_RDBIN: begin
            // second stage: colour of the bin's slot
            res_next.palette_index = b_rdata.slot;
            res_next.is_top = b_rdata.top;
            s_raddr = b_rdata.slot;
            state_next = ST_PICK_RD;
          end
          default: begin
            res_next.palette_index = req.slot_number;
            {res_next.out_hue, res_next.out_sat, res_next.out_light} = s_rdata;
            state_next = ST_OUT;
          end
        endcase
      end
      ST_OUT: begin
        if (out_ch.ready) state_next = ST_IDLE;
      end
      // maximum search: stream bins, one read per cycle
      ST_SRCH_RD: begin
        b_raddr = 13'd0;
        idx_next = 14'd1;
        state_next = ST_SRCH;
      end
      ST_SRCH: begin
        b_raddr = idx[12:0];
        if (b_rdata.count > best && b_rdata.count != UsedMark) begin
          best_next = b_rdata.count;
          pick_next = 13'(idx - 14'd1);
        end
        if (idx == 14'(BinDepth)) state_next = ST_PICK_RD;
        else idx_next = idx + 14'd1;
      end
      ST_PICK_RD: begin
        if (cmd_t'(req.cmd) == CMD_RDBIN) begin
          {res_next.out_hue, res_next.out_sat, res_next.out_light} = s_rdata;
          state_next = ST_OUT;
        end else begin
          b_raddr = pick;
          state_next = ST_PICK_WR;
        end
      end
      ST_PICK_WR: begin
        s_we = 1'b1;
        s_waddr = slot[7:0];
        if (best == '0) begin
          s_wdata = '0;
        end else begin
          s_wdata = b_rdata.colour;
          b_we = 1'b1;
          b_waddr = pick;
          b_wdata = b_rdata;
          b_wdata.count = UsedMark;
          b_wdata.top = 1'b1;
          b_wdata.slot = slot[7:0];
          filled_next = filled + 9'd1;
        end
        best_next = '0; pick_next = '0; idx_next = '0;
        slot_next = slot + 9'd1;
        if (slot == 9'(SlotDepth - 1)) state_next = ST_MAP_RD;
        else state_next = ST_SRCH_RD;
      end
      // nearest-slot mapping of every unused bin
      ST_MAP_RD: begin
        b_raddr = idx[12:0];
        state_next = ST_MAP_BIN;
      end
      ST_MAP_BIN: begin
        if (b_rdata.count == UsedMark) begin
          if (idx == 14'(BinDepth - 1)) begin
            slots_filled_next = filled;
            res_next = '0;
            res_next.used_slots = filled;
            state_next = ST_OUT;
          end else begin
            idx_next = idx + 14'd1;
            state_next = ST_MAP_RD;
          end
        end else begin
          cur_next = b_rdata;
          dbest_next = '1;
          dslot_next = '0;
          slot_next = 9'd0;
          s_raddr = 8'd0;
          rd_pipe_next = 1'b1;
          slot_next = 9'd1;
          state_next = ST_MAP_SLOT;
        end
      end
      ST_MAP_SLOT: begin
        s_raddr = slot[7:0];
        if (rd_pipe) begin
          if (slot_cost < dbest) begin
            dbest_next = slot_cost;
            dslot_next = 8'(slot - 9'd1);
          end
        end
        if (slot == 9'(SlotDepth)) state_next = ST_MAP_WR;
        else begin
          slot_next = slot + 9'd1;
          rd_pipe_next = 1'b1;
        end
      end
      ST_MAP_WR: begin
        b_we = 1'b1;
        b_waddr = idx[12:0];
        b_wdata = cur;
        b_wdata.count = UsedMark;
        b_wdata.slot = dslot;
        if (idx == 14'(BinDepth - 1)) begin
          slots_filled_next = filled;
          res_next = '0;
          res_next.used_slots = filled;
          state_next = ST_OUT;
        end else begin
          idx_next = idx + 14'd1;
          state_next = ST_MAP_RD;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end
endmodule
`default_nettype wire

// File: hw/rtl/ppb_ram.sv
// generic single-port-write, one-read RAM with registered read
`default_nettype none
module ppb_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output logic      [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// File: hw/rtl/ppb_checker.sv
// port-level checker for the palette builder, bound to the top level
`default_nettype none
module ppb_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic [8:0] used_slots
);
  a_no_accept_while_result: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready) else $error("input taken while result pending");
  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");
  a_used_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> used_slots <= 9'd256) else $error("used slots out of range");
  a_ready_after_out: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready |=> in_ready) else $error("not ready after result");
endmodule

bind popularity_palette_builder ppb_checker u_ppb_checker (
  .clk(clk), .rst(rst), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .used_slots(out_ch.data.used_slots));
`default_nettype wire

// File: dv/tb_popularity_palette_builder.sv
// testbench for the popularity palette builder: random load/build/read traffic, scoreboard check
module tb_popularity_palette_builder;
  import ppb_pkg::*;

  // palette predictor and store of expected results
  class palette_scoreboard;
    logic [12:0] hist_colour [BinDepth];
    logic [31:0] hist_weight [BinDepth];
    logic [7:0]  hist_slot [BinDepth];
    logic        hist_top [BinDepth];
    logic [12:0] pal_colour [SlotDepth];
    logic [8:0]  filled;
    out_item_t   expected_q [$];
    int          mismatches;

    function void clear_state();
      for (int i = 0; i < BinDepth; i++) begin
        hist_colour[i] = '0;
        hist_weight[i] = '0;
        hist_slot[i]   = '0;
        hist_top[i]    = 1'b0;
      end
      for (int t = 0; t < SlotDepth; t++) pal_colour[t] = '0;
      filled = '0;
      mismatches = 0;
    endfunction

    // trunc(d*d/255) with d = trunc(diff*255/levels), signed truncation
    function int unsigned axis_cost(int a, int b, int levels);
      int d;
      d = (a - b) * 255 / levels;
      return d * d / 255;
    endfunction

    function int unsigned colour_cost(logic [12:0] p, logic [12:0] q);
      return axis_cost(int'(p[12:8]), int'(q[12:8]), 32)
           + axis_cost(int'(p[7:4]), int'(q[7:4]), 16)
           + axis_cost(int'(p[3:0]), int'(q[3:0]), 16);
    endfunction

    function void build_palette();
      logic [31:0] best_cnt;
      int unsigned pick;
      int unsigned best_cost;
      int unsigned c;
      int unsigned n;
      n = 0;
      // popularity pass: largest unused count, lowest bin on ties
      for (int t = 0; t < SlotDepth; t++) begin
        best_cnt = '0;
        pick = 0;
        for (int i = 0; i < BinDepth; i++) begin
          if (hist_weight[i] > best_cnt && hist_weight[i] != UsedMark) begin
            best_cnt = hist_weight[i];
            pick = i;
          end
        end
        if (best_cnt == 0) begin
          pal_colour[t] = '0;
        end else begin
          hist_weight[pick] = UsedMark;
          hist_top[pick]    = 1'b1;
          hist_slot[pick]   = t[7:0];
          pal_colour[t]     = hist_colour[pick];
          n++;
        end
      end
      // nearest slot for the rest, first slot wins ties
      for (int i = 0; i < BinDepth; i++) begin
        if (hist_weight[i] != UsedMark) begin
          hist_weight[i] = UsedMark;
          best_cost = 32'hFFFF_FFFF;
          for (int t = 0; t < SlotDepth; t++) begin
            c = colour_cost(hist_colour[i], pal_colour[t]);
            if (c < best_cost) begin
              best_cost = c;
              hist_slot[i] = t[7:0];
            end
          end
        end
      end
      filled = n[8:0];
    endfunction

    function void note_input(in_item_t it);
      out_item_t r;
      r = '0;
      r.used_slots = filled;
      case (cmd_t'(it.cmd))
        CMD_LOAD: begin
          hist_colour[it.bin_number] = {it.src_hue, it.src_sat, it.src_light};
          hist_weight[it.bin_number] = (it.bin_weight == UsedMark) ? WeightMax : it.bin_weight;
          hist_top[it.bin_number]    = 1'b0;
          return;
        end
        CMD_BUILD: begin
          build_palette();
          r.used_slots = filled;
        end
        CMD_RDBIN: begin
          r.palette_index = hist_slot[it.bin_number];
          {r.out_hue, r.out_sat, r.out_light} = pal_colour[hist_slot[it.bin_number]];
          r.is_top = hist_top[it.bin_number];
        end
        default: begin
          r.palette_index = it.slot_number;
          {r.out_hue, r.out_sat, r.out_light} = pal_colour[it.slot_number];
        end
      endcase
      expected_q.push_back(r);
    endfunction

    function void check_result(out_item_t got);
      out_item_t exp_r;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", got);
        return;
      end
      exp_r = expected_q.pop_front();
      if (got.palette_index !== exp_r.palette_index || got.out_hue !== exp_r.out_hue ||
          got.out_sat !== exp_r.out_sat || got.out_light !== exp_r.out_light ||
          got.is_top !== exp_r.is_top || got.used_slots !== exp_r.used_slots) begin
        mismatches++;
        if (mismatches <= 10) $display("result differs: expected %p, actual %p", exp_r, got);
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  ppb_in_if  in_ch ();
  ppb_out_if out_ch ();

  popularity_palette_builder u_top (
    .clk   (clk),
    .rst   (rst),
    .in_ch (in_ch.sink),
    .out_ch(out_ch.source)
  );

  palette_scoreboard sb = new;
  bit steady_run;  // stretch with no idling on the input side
  int out_hold;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // mostly short gaps, a few long ones
  function int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  // one transfer on the input channel; valid stays high across back-to-back items
  task automatic send(in_item_t it);
    int gap;
    if ($urandom_range(0, 49) == 0) steady_run = !steady_run;
    gap = steady_run ? 0 : pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= it;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_input(it);
  endtask

  task automatic load(int bin, int h, int s, int l, logic [31:0] w);
    in_item_t it;
    it = '0;
    it.cmd = CMD_LOAD;
    it.bin_number = 13'(bin);
    it.src_hue = 5'(h);
    it.src_sat = 4'(s);
    it.src_light = 4'(l);
    it.bin_weight = w;
    it.slot_number = 8'($urandom);
    send(it);
  endtask

  task automatic command(cmd_t c, int bin, int slot);
    in_item_t it;
    it = in_item_t'({4'($urandom), $urandom, $urandom});  // unused fields carry noise
    it.bin_weight = $urandom;
    it.cmd = c;
    it.bin_number = 13'(bin);
    it.slot_number = 8'(slot);
    send(it);
  endtask

  // result side: random stalls, transfer checked on the sampled edge
  initial begin
    out_ch.ready = 1'b0;
    out_hold = 0;
    forever begin
      @(posedge clk);
      if (!rst && out_ch.valid && out_ch.ready) sb.check_result(out_ch.data);
      if (rst) begin
        out_ch.ready <= 1'b0;
      end else if (out_hold > 0) begin
        out_hold--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
        if ($urandom_range(0, 3) == 0) out_hold = pick_gap();
      end
    end
  end

  // generous bound covering the three builds of the run
  initial begin
    #400000000;
    $display("Mismatches found");
    $finish;
  end

  initial begin
    int r;
    int bin;
    logic [31:0] w;
    sb.clear_state();
    steady_run = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.data  = '0;
    rst = 1'b1;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: reads of the cleared store, extremes, ties, rebuild without reload
    command(CMD_RDSLT, 0, 0);
    command(CMD_RDBIN, 0, 0);
    load(0, 31, 15, 15, 32'hFFFF_FFFF);     // saturated weight
    load(8191, 0, 0, 0, 32'hFFFF_FFFE);     // ties with bin 0, lower bin wins
    load(100, 16, 8, 7, 5);
    load(101, 3, 2, 1, 5);
    load(200, 31, 0, 15, 0);                // zero count gets mapped, not picked
    load(8190, 10, 5, 9, 1);
    command(CMD_BUILD, 0, 0);
    command(CMD_RDBIN, 0, 0);
    command(CMD_RDBIN, 8191, 0);
    command(CMD_RDBIN, 100, 0);
    command(CMD_RDBIN, 101, 0);
    command(CMD_RDBIN, 200, 0);
    command(CMD_RDBIN, 5, 0);
    command(CMD_RDSLT, 0, 3);
    command(CMD_RDSLT, 0, 4);
    command(CMD_RDSLT, 0, 255);
    command(CMD_BUILD, 0, 0);               // every bin used: empty palette
    command(CMD_RDSLT, 0, 0);
    command(CMD_RDBIN, 200, 0);
    load(0, 1, 1, 1, 7);                    // reload clears the top flag
    command(CMD_RDBIN, 0, 0);

    // random: loads and reads, one build in the middle
    for (int n = 0; n < 1750; n++) begin
      if (n == 1000) begin
        command(CMD_BUILD, 0, 0);
      end else begin
        r = $urandom_range(0, 99);
        bin = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 8191) : $urandom_range(0, 63);
        if (r < 50) begin
          case ($urandom_range(0, 3))
            0: w = $urandom;
            1: w = 32'hFFFF_FFFF - $urandom_range(0, 1);
            default: w = $urandom_range(0, 8);
          endcase
          load(bin, $urandom_range(0, 31), $urandom_range(0, 15), $urandom_range(0, 15), w);
        end else if (r < 75) begin
          command(CMD_RDBIN, bin, 0);
        end else begin
          command(CMD_RDSLT, 0, $urandom_range(0, 255));
        end
      end
    end
    in_ch.valid <= 1'b0;

    while (sb.expected_q.size() > 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule

// File: files.f
hw/rtl/ppb_pkg.sv
hw/rtl/ppb_if.sv
hw/rtl/ppb_ram.sv
hw/rtl/popularity_palette_builder.sv
hw/rtl/ppb_checker.sv
dv/tb_popularity_palette_builder.sv
